// ===== hw/rtl/u8punct_pkg.sv =====
// Shared types and constants for the UTF-8 punctuation to ASCII core.
// No dependencies; u8punct_decode, u8punct_emit, the top level and the checker refer to this package.

package u8punct_pkg;

    // Byte patterns of UTF-8 lead and continuation bytes
    localparam logic [7:0] LEAD_PUNCT   = 8'hE2;
    localparam logic [7:0] SECOND_PUNCT = 8'h80;
    localparam logic [7:0] MASK3        = 8'hE0;
    localparam logic [7:0] MASK4        = 8'hF0;
    localparam logic [7:0] MASK5        = 8'hF8;
    localparam logic [7:0] PAT2         = 8'hC0;
    localparam logic [7:0] PAT3         = 8'hE0;
    localparam logic [7:0] PAT4         = 8'hF0;

    // Third byte of E2 80 xx
    localparam logic [7:0] RSQUO_LO = 8'h98;
    localparam logic [7:0] RSQUO_HI = 8'h99;
    localparam logic [7:0] RDQUO_LO = 8'h9C;
    localparam logic [7:0] RDQUO_HI = 8'h9D;
    localparam logic [7:0] DASH_LO  = 8'h93;
    localparam logic [7:0] DASH_HI  = 8'h94;
    localparam logic [7:0] ELLIPSIS = 8'hA6;

    // ASCII replacements
    localparam logic [6:0] CH_APOS   = 7'h27;
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_HYPHEN = 7'h2D;
    localparam logic [6:0] CH_DOT    = 7'h2E;

    // Result run lengths
    localparam logic [1:0] RUN_NONE     = 2'd0;
    localparam logic [1:0] RUN_ONE      = 2'd1;
    localparam logic [1:0] RUN_ELLIPSIS = 2'd3;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_E2    = 4'b0010,
        MODE_E280  = 4'b0100,
        MODE_DROP  = 4'b1000
    } mode_t;

    // One decoded byte: character and how many copies of it to emit
    typedef struct packed {
        logic [1:0] count;
        logic [6:0] ch;
    } res_t;

endpackage

// ===== hw/rtl/u8punct_ifs.sv =====
// Valid/ready channel interfaces for the UTF-8 punctuation core.
// Byte channel in, ASCII character channel out; no dependencies.

interface u8punct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, byte_in, end_of_text, input ready);
    modport sink   (input valid, byte_in, end_of_text, output ready);
endinterface

interface u8punct_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_out;
    logic       run_last;

    modport source (output valid, char_out, run_last, input ready);
    modport sink   (input valid, char_out, run_last, output ready);
endinterface

// ===== hw/rtl/u8punct_decode.sv =====
// Byte decoder: sequence state registers plus the per-byte mapping logic.
// Depends on u8punct_pkg.

module u8punct_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          byte_in,
    input  logic                end_of_text,
    input  logic                step,
    output u8punct_pkg::res_t   res
);

    u8punct_pkg::mode_t mode_reg;
    u8punct_pkg::mode_t mode_next;
    logic [1:0]         drop_reg;
    logic [1:0]         drop_next;

    always_comb
    begin
        mode_next = mode_reg;
        drop_next = drop_reg;
        res.count = u8punct_pkg::RUN_NONE;
        res.ch    = byte_in[6:0];
        unique case (mode_reg)
            u8punct_pkg::MODE_PLAIN:
            begin
                if (!byte_in[7])
                begin
                    res.count = u8punct_pkg::RUN_ONE;
                end
                else if (byte_in == u8punct_pkg::LEAD_PUNCT)
                begin
                    mode_next = u8punct_pkg::MODE_E2;
                end
                else if ((byte_in & u8punct_pkg::MASK3) == u8punct_pkg::PAT2)
                begin
                    mode_next = u8punct_pkg::MODE_DROP;
                    drop_next = 2'd1;
                end
                else if ((byte_in & u8punct_pkg::MASK4) == u8punct_pkg::PAT3)
                begin
                    mode_next = u8punct_pkg::MODE_DROP;
                    drop_next = 2'd2;
                end
                else if ((byte_in & u8punct_pkg::MASK5) == u8punct_pkg::PAT4)
                begin
                    mode_next = u8punct_pkg::MODE_DROP;
                    drop_next = 2'd3;
                end
            end
            u8punct_pkg::MODE_E2:
            begin
                if (byte_in == u8punct_pkg::SECOND_PUNCT)
                begin
                    mode_next = u8punct_pkg::MODE_E280;
                end
                else
                begin
                    mode_next = u8punct_pkg::MODE_DROP;
                    drop_next = 2'd1;
                end
            end
            u8punct_pkg::MODE_E280:
            begin
                mode_next = u8punct_pkg::MODE_PLAIN;
                case (byte_in)
                    u8punct_pkg::RSQUO_LO, u8punct_pkg::RSQUO_HI:
                    begin
                        res.count = u8punct_pkg::RUN_ONE;
                        res.ch    = u8punct_pkg::CH_APOS;
                    end
                    u8punct_pkg::RDQUO_LO, u8punct_pkg::RDQUO_HI:
                    begin
                        res.count = u8punct_pkg::RUN_ONE;
                        res.ch    = u8punct_pkg::CH_QUOTE;
                    end
                    u8punct_pkg::DASH_LO, u8punct_pkg::DASH_HI:
                    begin
                        res.count = u8punct_pkg::RUN_ONE;
                        res.ch    = u8punct_pkg::CH_HYPHEN;
                    end
                    u8punct_pkg::ELLIPSIS:
                    begin
                        res.count = u8punct_pkg::RUN_ELLIPSIS;
                        res.ch    = u8punct_pkg::CH_DOT;
                    end
                    default:
                    begin
                        res.count = u8punct_pkg::RUN_NONE;
                    end
                endcase
            end
            u8punct_pkg::MODE_DROP:
            begin
                // a zero count here is treated as one byte left
                if (drop_reg <= 2'd1)
                begin
                    mode_next = u8punct_pkg::MODE_PLAIN;
                    drop_next = 2'd0;
                end
                else
                begin
                    drop_next = drop_reg - 2'd1;
                end
            end
            default:
            begin
                mode_next = u8punct_pkg::MODE_PLAIN;
                drop_next = 2'd0;
            end
        endcase
        if (end_of_text)
        begin
            mode_next = u8punct_pkg::MODE_PLAIN;
            drop_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= u8punct_pkg::MODE_PLAIN;
            drop_reg <= 2'd0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            drop_reg <= drop_next;
        end
    end

endmodule

// ===== hw/rtl/u8punct_emit.sv =====
// Result register: holds one decoded character and replays it count times.
// Depends on u8punct_pkg.

module u8punct_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u8punct_pkg::res_t   load_res,
    output logic                free,
    output logic                valid,
    input  logic                ready,
    output logic [6:0]          char_out,
    output logic                run_last
);

    logic       valid_reg;
    logic [1:0] cnt_reg;
    logic [6:0] ch_reg;
    logic       xfer;

    assign xfer     = valid_reg && ready;
    assign free     = !valid_reg || (xfer && cnt_reg == u8punct_pkg::RUN_ONE);
    assign valid    = valid_reg;
    assign char_out = ch_reg;
    assign run_last = (cnt_reg == u8punct_pkg::RUN_ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= load_res.count;
        end
        else if (xfer)
        begin
            valid_reg <= (cnt_reg != u8punct_pkg::RUN_ONE);
            cnt_reg   <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ch_reg <= load_res.ch;
        end
    end

endmodule

// ===== hw/rtl/utf8_punctuation_to_ascii_core.sv =====
// Top level of the UTF-8 punctuation to ASCII core.
// Depends on u8punct_pkg, u8punct_ifs, u8punct_decode and u8punct_emit.
//
//  channel   | dir | payload                       | handshake
//  ----------+-----+-------------------------------+-------------
//  byte_ch   | in  | byte_in[7:0], end_of_text     | valid/ready
//  char_ch   | out | char_out[6:0], run_last       | valid/ready
//
// One byte per cycle unless a byte waits for a busy result register:
// input register -> decoder -> result register. A byte is registered in
// the input register, decoded, and its first character is registered in the
// result register. An ellipsis holds the result register for three character
// transfers; all other bytes give zero or one character. Bytes that give
// nothing retire from the input register even while the result register is
// stalled. rst_n clears the sequence state and both valid flags asynchronously.

module utf8_punctuation_to_ascii_core (
    input  logic              clk,
    input  logic              rst_n,
    u8punct_byte_if.sink      byte_ch,
    u8punct_char_if.source    char_ch
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;

    u8punct_pkg::res_t res;
    logic              emit_free;
    logic              consume;
    logic              load;

    // a byte leaves the input register when its characters fit in the
    // result register, or at once when it gives none
    assign consume = in_valid_reg && ((res.count == u8punct_pkg::RUN_NONE) || emit_free);
    assign load    = consume && (res.count != u8punct_pkg::RUN_NONE);

    assign byte_ch.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            in_byte_reg <= byte_ch.byte_in;
            in_eot_reg  <= byte_ch.end_of_text;
        end
    end

    u8punct_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_in     (in_byte_reg),
        .end_of_text (in_eot_reg),
        .step        (consume),
        .res         (res)
    );

    u8punct_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .load_res (res),
        .free     (emit_free),
        .valid    (char_ch.valid),
        .ready    (char_ch.ready),
        .char_out (char_ch.char_out),
        .run_last (char_ch.run_last)
    );

endmodule

// ===== hw/rtl/u8punct_checker.sv =====
// Port-level checks for utf8_punctuation_to_ascii_core, bound to the top level.
// Depends on u8punct_pkg.

module u8punct_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [6:0] char_out,
    input  logic       run_last
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(run_last))
        else $error("result changed while stalled");

    // only the ellipsis gives more than one character per byte
    a_multi_is_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> char_out == u8punct_pkg::CH_DOT)
        else $error("multi-character run is not an ellipsis");

    // a run continues right after a non-final transfer
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && char_out == u8punct_pkg::CH_DOT)
        else $error("ellipsis run broken");

    // input only stalls behind a pending character
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty result register");

endmodule

bind utf8_punctuation_to_ascii_core u8punct_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (byte_ch.ready),
    .out_valid (char_ch.valid),
    .out_ready (char_ch.ready),
    .char_out  (char_ch.char_out),
    .run_last  (char_ch.run_last)
);
